FILE: hw/rtl/pltf_pkg.sv
// Shared types and constants for the page translator with LRU frame replacement.
// No dependencies; imported by every module of the block.
package pltf_pkg;

    localparam int ADDR_W      = 32;
    localparam int PAGE_W      = 20;
    localparam int STAMP_W     = 32;
    localparam int FRAME_OUT_W = 6;
    localparam int ENTRY_W     = PAGE_W + STAMP_W;
    localparam int RES_W       = FRAME_OUT_W + 2 + PAGE_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // entry layout: owner page above, stamp below
    localparam int ENT_PAGE_LO  = STAMP_W;
    localparam int ENT_STAMP_LO = 0;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    typedef struct packed {
        logic clear;   // new transaction: restart tracking
        logic sample;  // read data valid for the sampled index
    } t_scan_ctl;

endpackage

FILE: hw/rtl/pltf_frame_store.sv
// Frame table memory: owner page and LRU stamp per frame, one write and one read port.
// Depends on pltf_pkg for entry width.
module pltf_frame_store #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [IW-1:0]               i_waddr,
    input  logic [pltf_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [IW-1:0]               i_raddr,
    output logic [pltf_pkg::ENTRY_W-1:0] o_rdata
);
    import pltf_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pltf_lru_scan.sv
// Scan tracker: first frame holding the page, and oldest stamp (lowest index on ties).
// Depends on pltf_pkg for widths and the scan control struct.
module pltf_lru_scan #(
    parameter int IW = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pltf_pkg::t_scan_ctl          i_ctl,
    input  logic [IW-1:0]                i_idx,
    input  logic [pltf_pkg::PAGE_W-1:0]  i_page,
    input  logic [pltf_pkg::ENTRY_W-1:0] i_entry,
    output logic                         o_hit,
    output logic [IW-1:0]                o_hit_idx,
    output logic [IW-1:0]                o_old_idx,
    output logic [pltf_pkg::PAGE_W-1:0]  o_old_page
);
    import pltf_pkg::*;

    logic               r_hit, n_hit;
    logic               r_have_old, n_have_old;
    logic [IW-1:0]      r_hit_idx, n_hit_idx;
    logic [IW-1:0]      r_old_idx, n_old_idx;
    logic [PAGE_W-1:0]  r_old_page, n_old_page;
    logic [STAMP_W-1:0] r_old_stamp, n_old_stamp;
    logic [PAGE_W-1:0]  ent_page;
    logic [STAMP_W-1:0] ent_stamp;

    assign ent_page  = i_entry[ENT_PAGE_LO +: PAGE_W];
    assign ent_stamp = i_entry[ENT_STAMP_LO +: STAMP_W];

    always_comb begin
        n_hit       = r_hit;
        n_have_old  = r_have_old;
        n_hit_idx   = r_hit_idx;
        n_old_idx   = r_old_idx;
        n_old_page  = r_old_page;
        n_old_stamp = r_old_stamp;
        if (i_ctl.clear) begin
            n_hit      = 1'b0;
            n_have_old = 1'b0;
        end else if (i_ctl.sample) begin
            if (!r_hit && ent_page == i_page) begin
                n_hit     = 1'b1;
                n_hit_idx = i_idx;
            end
            // strict compare keeps the lowest index on equal stamps
            if (!r_have_old || ent_stamp < r_old_stamp) begin
                n_have_old  = 1'b1;
                n_old_stamp = ent_stamp;
                n_old_idx   = i_idx;
                n_old_page  = ent_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_have_old <= 1'b0;
        end else begin
            r_hit      <= n_hit;
            r_have_old <= n_have_old;
        end
        r_hit_idx   <= n_hit_idx;
        r_old_idx   <= n_old_idx;
        r_old_page  <= n_old_page;
        r_old_stamp <= n_old_stamp;
    end

    assign o_hit      = r_hit;
    assign o_hit_idx  = r_hit_idx;
    assign o_old_idx  = r_old_idx;
    assign o_old_page = r_old_page;

endmodule

FILE: hw/rtl/page_translate_lru_frames_unit.sv
// Top level of the page translator: control FSM, request counter, fill count, result register.
// Depends on pltf_pkg, pltf_frame_store and pltf_lru_scan.
//
//  channel   dir  handshake                         payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tdata[31:0] virtual_address
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata[27:0] frame, hit, evict, page
//
// Flow: each item reads every frame in use from the frame table, waits
//   until the last read has landed in the tracker, then writes back and
//   returns to idle; an item takes longer as the table fills, and longest
//   once every frame is occupied. A new item is taken only in idle. The
//   single read port of the frame table sets this.
// Reset: synchronous, active low; clears the fill count (all frames free),
//   the counter and the handshake state. The table itself is not cleared.
// Stalls: a finished result sits in the output register; the next
//   transaction is taken meanwhile, and only its write-back waits for room.
module page_translate_lru_frames_unit #(
    parameter int NUM_FRAMES       = 64,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [pltf_pkg::ADDR_W-1:0]        i_s_axis_tdata,  // [31:0] virtual_address
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [5:0] frame_index, [6] was_hit, [7] did_evict, [27:8] evicted_page, [31:28] zero
    output logic [pltf_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import pltf_pkg::*;

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    t_state             r_state, n_state;
    logic [STAMP_W-1:0] r_counter, n_counter;
    logic [CW-1:0]      r_fill, n_fill;
    logic [CW-1:0]      r_rd_cnt, n_rd_cnt;
    logic               r_smp_vld;
    logic [IW-1:0]      r_smp_idx;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic               r_out_vld, n_out_vld;
    logic [RES_W-1:0]   r_out_data, n_out_data;

    logic               accept;
    logic               rd_en;
    logic               load;
    logic               have_free;
    logic [IW-1:0]      frame;
    logic               evict;
    logic [PAGE_W-1:0]  evicted;
    logic [ENTRY_W-1:0] rd_entry;
    logic               scan_hit;
    logic [IW-1:0]      scan_hit_idx;
    logic [IW-1:0]      scan_old_idx;
    logic [PAGE_W-1:0]  scan_old_page;
    t_scan_ctl          scan_ctl;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // reads walk the occupied prefix of the table; frames are never freed
    assign rd_en     = (r_state == S_SCAN) && (r_rd_cnt != r_fill);
    assign have_free = (r_fill != CW'(NUM_FRAMES));
    assign load      = (r_state == S_WRITE) && (!r_out_vld || i_m_axis_tready);

    // hit first, then lowest free frame, else the oldest one goes
    always_comb begin
        evict   = 1'b0;
        evicted = '0;
        if (scan_hit) begin
            frame = scan_hit_idx;
        end else if (have_free) begin
            frame = r_fill[IW-1:0];
        end else begin
            frame   = scan_old_idx;
            evict   = 1'b1;
            evicted = scan_old_page;
        end
    end

    assign scan_ctl.clear  = accept;
    assign scan_ctl.sample = r_smp_vld;

    always_comb begin
        n_state    = r_state;
        n_counter  = r_counter;
        n_fill     = r_fill;
        n_rd_cnt   = r_rd_cnt;
        n_page     = r_page;
        n_out_data = r_out_data;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state  = S_SCAN;
                    n_rd_cnt = '0;
                    n_page   = PAGE_W'(i_s_axis_tdata >> PAGE_OFFSET_BITS);
                    if (r_counter != STAMP_MAX) begin
                        n_counter = r_counter + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end else if (!r_smp_vld) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (load) begin
                    n_state    = S_IDLE;
                    n_out_vld  = 1'b1;
                    n_out_data = {evicted, evict, scan_hit, FRAME_OUT_W'(frame)};
                    if (!scan_hit && have_free) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_counter <= '0;
            r_fill    <= '0;
            r_rd_cnt  <= '0;
            r_smp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_counter <= n_counter;
            r_fill    <= n_fill;
            r_rd_cnt  <= n_rd_cnt;
            r_smp_vld <= rd_en;
            r_out_vld <= n_out_vld;
        end
        r_smp_idx  <= r_rd_cnt[IW-1:0];
        r_page     <= n_page;
        r_out_data <= n_out_data;
    end

    pltf_frame_store #(
        .DEPTH (NUM_FRAMES),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (load),
        .i_waddr (frame),
        .i_wdata ({r_page, r_counter}),
        .i_re    (rd_en),
        .i_raddr (r_rd_cnt[IW-1:0]),
        .o_rdata (rd_entry)
    );

    pltf_lru_scan #(
        .IW (IW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_idx      (r_smp_idx),
        .i_page     (r_page),
        .i_entry    (rd_entry),
        .o_hit      (scan_hit),
        .o_hit_idx  (scan_hit_idx),
        .o_old_idx  (scan_old_idx),
        .o_old_page (scan_old_page)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_out_data};

endmodule

FILE: hw/rtl/pltf_checker.sv
// Port-level checks for the page translator, bound to the top level.
// Depends on pltf_pkg for port widths.
module pltf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [pltf_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import pltf_pkg::*;

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    a_rst_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("second transaction taken while one is in work");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[6] && o_m_axis_tdata[7]))
        else $error("hit and eviction flagged together");

    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[7]) |-> (o_m_axis_tdata[27:8] == '0))
        else $error("evicted page not zero without eviction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind page_translate_lru_frames_unit pltf_checker u_pltf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_translate_lru_frames_unit: directed and random address streams.
// Depends on pltf_pkg and the unit's RTL; it predicts every result with its own LRU frame table.
module tb;

    import pltf_pkg::*;

    // Default sizes only. Three cases cannot arise in this run. Counter saturation
    // (and with it stamp ties) needs 2**32 requests. Page truncation needs an
    // offset below 12 bits. Frame-index wrap needs more than 64 frames.
    localparam int N_FRAMES        = 64;
    localparam int OFFSET_BITS     = 12;
    localparam int WATCHDOG_CYCLES = 2000;          // far above one full scan plus stalls
    localparam int DRAIN_CYCLES    = 4 * (N_FRAMES + 3);

    // Result as it sits in o_m_axis_tdata, lowest field last in the declaration
    typedef struct packed {
        logic [OUT_TDATA_W-RES_W-1:0] pad;
        logic [PAGE_W-1:0]            evicted_page;
        logic                         did_evict;
        logic                         was_hit;
        logic [FRAME_OUT_W-1:0]       frame_index;
    } t_frame_result;

    // ---------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ---------------------------------------------------------------------
    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    logic [ADDR_W-1:0]       s_data  = '0;
    logic                    m_ready = 1'b0;
    logic                    o_s_axis_tready;
    logic                    o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    page_translate_lru_frames_unit #(
        .NUM_FRAMES       (N_FRAMES),
        .PAGE_OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // [31:0] virtual_address
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)   // [5:0] frame, [6] hit, [7] evict, [27:8] page
    );

    // ---------------------------------------------------------------------
    // Predicted frame table: in-use flags, owner pages, LRU stamps, counter
    // ---------------------------------------------------------------------
    bit                 frame_busy  [N_FRAMES];
    logic [PAGE_W-1:0]  frame_page  [N_FRAMES];
    logic [STAMP_W-1:0] frame_touch [N_FRAMES];
    logic [STAMP_W-1:0] use_count = '0;

    t_frame_result expected_frames[$];   // one entry per accepted address, oldest first
    int            mismatches = 0;
    bit            no_idle    = 1'b0;    // forces back-to-back traffic on both sides

    // Updates the predicted table for one request and returns the result it gives
    function automatic t_frame_result translate_page(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] oldest_touch;
        int                 hit_at, free_at, oldest_at, slot;
        t_frame_result      r;
        page         = PAGE_W'(addr >> OFFSET_BITS);
        oldest_touch = '0;
        hit_at       = -1;
        free_at      = -1;
        oldest_at    = -1;
        slot         = 0;
        if (use_count != STAMP_MAX) use_count = use_count + 1'b1;
        for (int i = 0; i < N_FRAMES; i++) begin
            if (frame_busy[i]) begin
                if (hit_at < 0 && frame_page[i] == page) hit_at = i;
                // strict compare: lowest index keeps a tie
                if (oldest_at < 0 || frame_touch[i] < oldest_touch) begin
                    oldest_at    = i;
                    oldest_touch = frame_touch[i];
                end
            end else if (free_at < 0) begin
                free_at = i;
            end
        end
        r = '0;
        if (hit_at >= 0) begin
            slot      = hit_at;
            r.was_hit = 1'b1;
        end else if (free_at >= 0) begin
            slot = free_at;
        end else begin
            // table full: the least recently touched frame gives up its page
            slot           = oldest_at;
            r.did_evict    = 1'b1;
            r.evicted_page = frame_page[slot];
        end
        frame_busy[slot]  = 1'b1;
        frame_page[slot]  = page;
        frame_touch[slot] = use_count;
        r.frame_index     = FRAME_OUT_W'(slot);
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle)   return 0;
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] page);
        return {page, OFFSET_BITS'($urandom)};
    endfunction

    // ---------------------------------------------------------------------
    // Sender: one transaction per call. tvalid stays high when the next
    // address follows at once, so it is never lowered and raised in one step.
    // ---------------------------------------------------------------------
    task automatic send_addr(input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= addr;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_frames.push_back(translate_page(addr));
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (expected_frames.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Receiver back-pressure: ready windows and stalls of random length
    // ---------------------------------------------------------------------
    int unsigned ready_hold = 0;

    always @(posedge i_clk) begin
        if (no_idle) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready) begin
            m_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 30);
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: each output transaction against the oldest prediction
    // ---------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame_result got, want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = t_frame_result'(o_m_axis_tdata);
            if (expected_frames.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got 0x%0h",
                         $time, o_m_axis_tdata);
            end else begin
                want = expected_frames.pop_front();
                check_field("frame_index",  32'(want.frame_index),  32'(got.frame_index));
                check_field("was_hit",      32'(want.was_hit),      32'(got.was_hit));
                check_field("did_evict",    32'(want.did_evict),    32'(got.did_evict));
                check_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
                check_field("tdata pad",    32'(want.pad),          32'(got.pad));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: too long without any transaction on either side
    // ---------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_frames.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Address extremes, offset bits that must not matter, first hits on fresh frames
    task automatic test_directed_extremes();
        send_addr(32'h0000_0000);   // miss into frame 0
        send_addr(32'hFFFF_FFFF);   // top page, next free frame
        send_addr(32'h0000_0FFF);   // same page as first, full offset: hit
        send_addr(32'hFFFF_F000);   // top page, zero offset: hit
        send_addr(32'h0000_1000);   // lowest page bit alone
        send_addr(32'h8000_0000);   // highest page bit alone
        send_addr(32'h7FFF_FFFF);
        send_addr(32'hAAAA_AAAA);
        send_addr(32'h5555_5555);
        send_addr(32'hAAAA_A555);   // hit with offset bits inverted
        send_addr(32'h0000_0123);   // page 0 again after others
        send_addr(32'h0000_0123);   // back-to-back repeat
        send_addr(32'hFFFF_E000);
        send_addr(32'h0000_2FFF);
        stop_sending();
    endtask

    // Fill the table, then fresh pages evict the least recent while recent ones hit
    task automatic test_lru_eviction();
        logic [PAGE_W-1:0] recent[16];
        logic [PAGE_W-1:0] page;
        int                head;
        head = 0;
        for (int i = 0; i < 16; i++) recent[i] = PAGE_W'($urandom);
        for (int n = 0; n < 130; n++) begin
            if (n < 56 || $urandom_range(0, 99) < 70) begin
                page         = PAGE_W'($urandom);
                recent[head] = page;
                head         = (head + 1) % 16;
            end else begin
                page = recent[$urandom_range(0, 15)];
            end
            send_addr(page_addr(page));
        end
        stop_sending();
    endtask

    // Working set a little larger than the table: hits, misses and evictions mixed
    task automatic test_working_set();
        logic [PAGE_W-1:0] pool[72];
        logic [PAGE_W-1:0] last_page;
        logic [ADDR_W-1:0] addr;
        int unsigned       roll;
        for (int i = 0; i < 72; i++) pool[i] = PAGE_W'($urandom);
        last_page = pool[0];
        for (int n = 0; n < 280; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 75)      addr = page_addr(pool[$urandom_range(0, 71)]);
            else if (roll < 90) addr = page_addr(last_page);
            else                addr = $urandom;
            last_page = PAGE_W'(addr >> OFFSET_BITS);
            send_addr(addr);
        end
        stop_sending();
    endtask

    // No idling on either side: a continuous stream of transactions
    task automatic test_back_to_back();
        logic [PAGE_W-1:0] pool[40];
        for (int i = 0; i < 40; i++) pool[i] = PAGE_W'($urandom);
        no_idle = 1'b1;
        for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 3) == 0) send_addr($urandom);
            else                           send_addr(page_addr(pool[$urandom_range(0, 39)]));
        end
        stop_sending();
        no_idle = 1'b0;
    endtask

    // Sender holds off until every outstanding result has been received
    task automatic test_drain_pauses();
        logic [PAGE_W-1:0] pool[20];
        for (int i = 0; i < 20; i++) pool[i] = PAGE_W'($urandom);
        for (int batch = 0; batch < 4; batch++) begin
            for (int n = 0; n < 15; n++) begin
                if ($urandom_range(0, 1) == 0) send_addr($urandom);
                else                           send_addr(page_addr(pool[$urandom_range(0, 19)]));
            end
            wait_drained();
        end
    endtask

    // Unrelated full-width addresses: nearly every one evicts
    task automatic test_random_noise();
        for (int n = 0; n < 60; n++) send_addr($urandom);
        stop_sending();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_lru_eviction();
        test_working_set();
        test_back_to_back();
        test_drain_pauses();
        test_random_noise();

        // everything sent: wait for the last results, then a few scans' worth more
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
